### rtl/core/amed_pkg.sv
// ----------------------------------------------------------------------------
// amed_pkg
// Shared constants and tables for the accelerometer motion event detector.
// ----------------------------------------------------------------------------
package amed_pkg;

    localparam int MAG_W  = 15;
    localparam int AXIS_W = 15;
    localparam int SQ_W   = 30;
    localparam int SUM_W  = 32;
    localparam int ROOT_W = 16;
    localparam int TILT_W = 11;
    localparam int ANG_W  = 10;
    localparam int ACC_W  = 20;
    localparam int CXY_W  = 33;
    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_SCALE = 14;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_FALL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIBE_DEV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIBE_WIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION    = 3'd5;

    localparam logic [11:0] RST_FREE_FALL = 12'd400;
    localparam logic [14:0] RST_IMPACT    = 15'd3000;
    localparam logic [10:0] RST_TILT      = 11'd600;
    localparam logic [13:0] RST_VIBE_DEV  = 14'd300;
    localparam logic [9:0]  RST_VIBE_WIN  = 10'd20;
    localparam logic [11:0] RST_MOTION    = 12'd150;

    localparam logic [MAG_W-1:0]  ONE_G_MG      = 15'd1000;
    localparam logic [MAG_W-1:0]  TILT_FLOOR_MG = 15'd100;
    localparam logic [ACC_W-1:0]  QUARTER_TURN  = 20'd230400;
    localparam logic [ACC_W-1:0]  ANG_ROUND     = 20'd128;
    localparam logic [ANG_W-1:0]  RIGHT_TENTHS  = 10'd900;
    localparam logic [TILT_W-1:0] MAX_TILT      = 11'd1800;
    localparam logic [15:0]       VIBE_MAX      = 16'hFFFF;

    function automatic logic [ACC_W-1:0] atan_entry(input logic [3:0] idx);
        logic [ACC_W-1:0] v;
        begin
            unique case (idx)
                4'd0:  v = 20'd115200;
                4'd1:  v = 20'd68007;
                4'd2:  v = 20'd35933;
                4'd3:  v = 20'd18240;
                4'd4:  v = 20'd9155;
                4'd5:  v = 20'd4582;
                4'd6:  v = 20'd2292;
                4'd7:  v = 20'd1146;
                4'd8:  v = 20'd573;
                4'd9:  v = 20'd286;
                4'd10: v = 20'd143;
                4'd11: v = 20'd72;
                4'd12: v = 20'd36;
                4'd13: v = 20'd18;
                default: v = 20'd0;
            endcase
            return v;
        end
    endfunction

endpackage

### rtl/core/amed_square.sv
// ----------------------------------------------------------------------------
// amed_square
// Bit-serial squarer, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module amed_square
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [amed_pkg::MAG_W-1:0]  op,
    output logic                        done,
    output logic [amed_pkg::SQ_W-1:0]   prod
);

    logic [amed_pkg::SQ_W-1:0]  mcand_reg;
    logic [amed_pkg::MAG_W-1:0] mplier_reg;
    logic [amed_pkg::SQ_W-1:0]  acc_reg;
    logic [3:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(amed_pkg::MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mcand_reg  <= {{(amed_pkg::SQ_W-amed_pkg::MAG_W){1'b0}}, op};
            mplier_reg <= op;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[amed_pkg::SQ_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[amed_pkg::MAG_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### rtl/core/amed_isqrt.sv
// ----------------------------------------------------------------------------
// amed_isqrt
// Digit-serial floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module amed_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [amed_pkg::SUM_W-1:0]   op,
    output logic                         done,
    output logic [amed_pkg::ROOT_W-1:0]  root
);

    localparam int REM_W = amed_pkg::ROOT_W + 4;

    logic [amed_pkg::SUM_W-1:0]  n_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [amed_pkg::ROOT_W-1:0] root_reg;
    logic [4:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [REM_W-1:0]            rem_sh;
    logic [REM_W-1:0]            trial;

    assign rem_sh = {rem_reg[REM_W-3:0], n_reg[amed_pkg::SUM_W-1:amed_pkg::SUM_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(amed_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            n_reg    <= op;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[amed_pkg::SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[amed_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[amed_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/core/amed_cordic.sv
// ----------------------------------------------------------------------------
// amed_cordic
// Iterative vectoring CORDIC giving atan2(y, x) in tenths of a degree.
// ----------------------------------------------------------------------------
module amed_cordic
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [amed_pkg::MAG_W-1:0]  x_in,
    input  logic [amed_pkg::MAG_W-1:0]  y_in,
    output logic                        done,
    output logic [amed_pkg::ANG_W-1:0]  tenths
);

    logic signed [amed_pkg::CXY_W-1:0] x_reg;
    logic signed [amed_pkg::CXY_W-1:0] y_reg;
    logic signed [amed_pkg::ACC_W-1:0] acc_reg;
    logic [3:0]                        step_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [amed_pkg::CXY_W-1:0]        x_mag;
    logic [amed_pkg::CXY_W-1:0]        y_mag;
    logic [amed_pkg::CXY_W-1:0]        dx;
    logic [amed_pkg::CXY_W-1:0]        dy;
    logic [amed_pkg::ACC_W-1:0]        ang;
    logic [amed_pkg::ACC_W-1:0]        acc_cl;
    logic [amed_pkg::ACC_W-1:0]        acc_rnd;
    logic [amed_pkg::ANG_W-1:0]        t_raw;

    always_comb
    begin
        y_mag = y_reg[amed_pkg::CXY_W-1] ? -y_reg : y_reg;
        x_mag = x_reg[amed_pkg::CXY_W-1] ? -x_reg : x_reg;
        dx    = y_reg[amed_pkg::CXY_W-1] ? -(y_mag >> step_reg) : (y_mag >> step_reg);
        dy    = x_reg[amed_pkg::CXY_W-1] ? -(x_mag >> step_reg) : (x_mag >> step_reg);
        ang   = amed_pkg::atan_entry(step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(amed_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            x_reg   <= signed'({{(amed_pkg::CXY_W-amed_pkg::MAG_W-amed_pkg::CORDIC_SCALE){1'b0}},
                               x_in, {amed_pkg::CORDIC_SCALE{1'b0}}});
            y_reg   <= signed'({{(amed_pkg::CXY_W-amed_pkg::MAG_W-amed_pkg::CORDIC_SCALE){1'b0}},
                               y_in, {amed_pkg::CORDIC_SCALE{1'b0}}});
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[amed_pkg::CXY_W-1])
            begin
                x_reg   <= x_reg + signed'(dx);
                y_reg   <= y_reg - signed'(dy);
                acc_reg <= acc_reg + signed'(ang);
            end
            else
            begin
                x_reg   <= x_reg - signed'(dx);
                y_reg   <= y_reg + signed'(dy);
                acc_reg <= acc_reg - signed'(ang);
            end
        end
    end

    always_comb
    begin
        if (acc_reg[amed_pkg::ACC_W-1])
        begin
            acc_cl = '0;
        end
        else if (acc_reg > signed'(amed_pkg::QUARTER_TURN))
        begin
            acc_cl = amed_pkg::QUARTER_TURN;
        end
        else
        begin
            acc_cl = acc_reg;
        end
        acc_rnd = acc_cl + amed_pkg::ANG_ROUND;
        t_raw   = acc_rnd[amed_pkg::ANG_W+7:8];
        tenths  = (t_raw > amed_pkg::RIGHT_TENTHS) ? amed_pkg::RIGHT_TENTHS : t_raw;
    end

    assign done = done_reg;

endmodule

### rtl/core/accel_motion_event_detector.sv
// ----------------------------------------------------------------------------
// accel_motion_event_detector
// Magnitude, smoothing, tilt and event flags for a three-axis accelerometer.
// ----------------------------------------------------------------------------
// One sample enters on the s_axis channel and one result leaves on m_axis.
// The block works on one sample at a time. Each sample passes through a
// bit-serial squarer three times, a two-bit-per-cycle square root and a
// bit-serial divide of the window sum by AVG_WINDOW. When the smoothed
// magnitude exceeds 100 mg, two more squarings, a second root and a 14-step
// CORDIC follow. The window sum is TOTAL_W bits wide (19 bits for a
// window of 8).
// The result waits in an output register; the next sample is accepted and
// worked on while it waits, and the block stalls only when a new result is
// ready before the old one is taken.
// After reset the window holds 1000 mg in every slot, the vibration counter
// and quake flag are clear and the registers hold their default values.
// Configuration writes are taken only while the block is idle between
// samples, and a pending write holds off the next input transaction.
// ----------------------------------------------------------------------------
module accel_motion_event_detector
#(
    parameter int AVG_WINDOW = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x_mg [14:0], accel_y_mg [29:15], accel_z_mg [44:30], zero [47:45]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // raw_magnitude_mg [14:0], smoothed_magnitude_mg [29:15], tilt_tenths [40:30],
    // motion_flag [41], free_fall_flag [42], impact_flag [43], tilt_flag [44],
    // quake_flag [45], zero [47:46]
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int POS_W   = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int TOTAL_W = amed_pkg::MAG_W + $clog2(AVG_WINDOW) + 1;
    localparam int DREM_W  = $clog2(AVG_WINDOW) + 1;
    localparam int DCNT_W  = $clog2(TOTAL_W + 1);
    localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(AVG_WINDOW * 1000);
    localparam logic [DREM_W:0]    WIN_DIV   = (DREM_W+1)'(AVG_WINDOW);
    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(AVG_WINDOW - 1);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SQ,
        S_ROOT1,
        S_RING,
        S_DIV,
        S_FF,
        S_ZZ,
        S_ROOT2,
        S_CORD,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [11:0] free_fall_reg;
    logic [14:0] impact_reg;
    logic [10:0] tilt_lim_reg;
    logic [13:0] vibe_dev_reg;
    logic [9:0]  vibe_win_reg;
    logic [11:0] motion_reg;

    logic [amed_pkg::AXIS_W-1:0] y_reg;
    logic [amed_pkg::AXIS_W-1:0] z_reg;
    logic [amed_pkg::SUM_W-1:0]  sum_reg;
    logic [1:0]                  axis_reg;
    logic [amed_pkg::MAG_W-1:0]  raw_reg;
    logic [amed_pkg::MAG_W-1:0]  smooth_reg;
    logic [amed_pkg::MAG_W-1:0]  zmag_reg;
    logic                        zneg_reg;
    logic [amed_pkg::SQ_W-1:0]   ff_reg;
    logic [amed_pkg::TILT_W-1:0] tilt_reg;
    logic [TOTAL_W-1:0]          total_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [AVG_WINDOW-1:0]       ring_vld_reg;
    logic [amed_pkg::MAG_W-1:0]  ring_mem [AVG_WINDOW];
    logic [amed_pkg::MAG_W-1:0]  ring_rd_reg;
    logic [TOTAL_W-1:0]          div_q_reg;
    logic [DREM_W-1:0]           div_rem_reg;
    logic [DCNT_W-1:0]           div_cnt_reg;
    logic [15:0]                 vibe_cnt_reg;
    logic                        quake_reg;

    logic                        sq_go_reg;
    logic [amed_pkg::MAG_W-1:0]  sq_op_reg;
    logic                        rt_go_reg;
    logic [amed_pkg::SUM_W-1:0]  rt_op_reg;
    logic                        cd_go_reg;
    logic [amed_pkg::MAG_W-1:0]  cd_x_reg;
    logic [amed_pkg::MAG_W-1:0]  cd_y_reg;

    logic                        sq_done;
    logic [amed_pkg::SQ_W-1:0]   sq_prod;
    logic                        rt_done;
    logic [amed_pkg::ROOT_W-1:0] rt_root;
    logic                        cd_done;
    logic [amed_pkg::ANG_W-1:0]  cd_tenths;

    logic                        out_valid_reg;
    logic [amed_pkg::MAG_W-1:0]  out_raw_reg;
    logic [amed_pkg::MAG_W-1:0]  out_smooth_reg;
    logic [amed_pkg::TILT_W-1:0] out_tilt_reg;
    logic                        out_motion_reg;
    logic                        out_ff_reg;
    logic                        out_impact_reg;
    logic                        out_tilt_flag_reg;
    logic                        out_quake_reg;

    logic                        in_fire;
    logic                        out_free;
    logic [amed_pkg::MAG_W-1:0]  in_x_abs;
    logic [amed_pkg::MAG_W-1:0]  y_abs;
    logic [amed_pkg::MAG_W-1:0]  z_abs;
    logic [amed_pkg::SUM_W-1:0]  sum_next;
    logic [amed_pkg::MAG_W-1:0]  ring_old;
    logic [TOTAL_W-1:0]          total_next;
    logic [DREM_W:0]             div_sh;
    logic [amed_pkg::MAG_W-1:0]  smooth_q;
    logic [amed_pkg::MAG_W-1:0]  dev_s;
    logic [amed_pkg::MAG_W-1:0]  dev_r;
    logic [15:0]                 vibe_next;
    logic                        quake_next;

    function automatic logic [amed_pkg::MAG_W-1:0] abs15(input logic [amed_pkg::AXIS_W-1:0] v);
        return v[amed_pkg::AXIS_W-1] ? (~v + 15'd1) : v;
    endfunction

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = (state_reg == S_IDLE);

    assign in_x_abs = abs15(s_axis_tdata[14:0]);
    assign y_abs    = abs15(y_reg);
    assign z_abs    = abs15(z_reg);
    assign sum_next = sum_reg + {{(amed_pkg::SUM_W-amed_pkg::SQ_W){1'b0}}, sq_prod};
    assign ring_old = ring_vld_reg[pos_reg] ? ring_rd_reg : amed_pkg::ONE_G_MG;
    assign total_next = total_reg - {{(TOTAL_W-amed_pkg::MAG_W){1'b0}}, ring_old}
                                  + {{(TOTAL_W-amed_pkg::MAG_W){1'b0}}, raw_reg};
    assign div_sh   = {div_rem_reg, div_q_reg[TOTAL_W-1]};
    assign smooth_q = div_q_reg[amed_pkg::MAG_W-1:0];

    always_comb
    begin
        dev_s = (smooth_reg > amed_pkg::ONE_G_MG) ? smooth_reg - amed_pkg::ONE_G_MG
                                                  : amed_pkg::ONE_G_MG - smooth_reg;
        dev_r = (raw_reg > amed_pkg::ONE_G_MG) ? raw_reg - amed_pkg::ONE_G_MG
                                               : amed_pkg::ONE_G_MG - raw_reg;
        quake_next = quake_reg;
        if (dev_r > {1'b0, vibe_dev_reg})
        begin
            vibe_next = (vibe_cnt_reg != amed_pkg::VIBE_MAX) ? vibe_cnt_reg + 16'd1
                                                             : vibe_cnt_reg;
            if (vibe_next >= {6'd0, vibe_win_reg})
            begin
                quake_next = 1'b1;
            end
        end
        else
        begin
            vibe_next = (vibe_cnt_reg != 16'd0) ? vibe_cnt_reg - 16'd1 : vibe_cnt_reg;
            if (vibe_next < {7'd0, vibe_win_reg[9:1]})
            begin
                quake_next = 1'b0;
            end
        end
    end

    amed_square u_square
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sq_go_reg),
        .op    (sq_op_reg),
        .done  (sq_done),
        .prod  (sq_prod)
    );

    amed_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (rt_go_reg),
        .op    (rt_op_reg),
        .done  (rt_done),
        .root  (rt_root)
    );

    amed_cordic u_cordic
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cd_go_reg),
        .x_in   (cd_x_reg),
        .y_in   (cd_y_reg),
        .done   (cd_done),
        .tenths (cd_tenths)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_fall_reg <= amed_pkg::RST_FREE_FALL;
            impact_reg    <= amed_pkg::RST_IMPACT;
            tilt_lim_reg  <= amed_pkg::RST_TILT;
            vibe_dev_reg  <= amed_pkg::RST_VIBE_DEV;
            vibe_win_reg  <= amed_pkg::RST_VIBE_WIN;
            motion_reg    <= amed_pkg::RST_MOTION;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                amed_pkg::CFG_FREE_FALL: free_fall_reg <= cfg_data[11:0];
                amed_pkg::CFG_IMPACT:    impact_reg    <= cfg_data[14:0];
                amed_pkg::CFG_TILT:      tilt_lim_reg  <= cfg_data[10:0];
                amed_pkg::CFG_VIBE_DEV:  vibe_dev_reg  <= cfg_data[13:0];
                amed_pkg::CFG_VIBE_WIN:  vibe_win_reg  <= cfg_data[9:0];
                amed_pkg::CFG_MOTION:    motion_reg    <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ring_rd_reg <= ring_mem[pos_reg];
        if (state_reg == S_RING)
        begin
            ring_mem[pos_reg] <= raw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sq_go_reg     <= 1'b0;
            rt_go_reg     <= 1'b0;
            cd_go_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= TOTAL_RST;
            pos_reg       <= '0;
            ring_vld_reg  <= '0;
            vibe_cnt_reg  <= '0;
            quake_reg     <= 1'b0;
            axis_reg      <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            sq_go_reg <= 1'b0;
            rt_go_reg <= 1'b0;
            cd_go_reg <= 1'b0;
            if (out_valid_reg && m_axis_tready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        axis_reg  <= 2'd0;
                        sq_go_reg <= 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (sq_done)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            rt_go_reg <= 1'b1;
                            state_reg <= S_ROOT1;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            sq_go_reg <= 1'b1;
                        end
                    end
                end
                S_ROOT1:
                begin
                    if (rt_done)
                    begin
                        state_reg <= S_RING;
                    end
                end
                S_RING:
                begin
                    total_reg             <= total_next;
                    ring_vld_reg[pos_reg] <= 1'b1;
                    pos_reg               <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                    div_cnt_reg           <= '0;
                    state_reg             <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_cnt_reg == DCNT_W'(TOTAL_W))
                    begin
                        if (smooth_q > amed_pkg::TILT_FLOOR_MG)
                        begin
                            sq_go_reg <= 1'b1;
                            state_reg <= S_FF;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                S_FF:
                begin
                    if (sq_done)
                    begin
                        sq_go_reg <= 1'b1;
                        state_reg <= S_ZZ;
                    end
                end
                S_ZZ:
                begin
                    if (sq_done)
                    begin
                        rt_go_reg <= 1'b1;
                        state_reg <= S_ROOT2;
                    end
                end
                S_ROOT2:
                begin
                    if (rt_done)
                    begin
                        cd_go_reg <= 1'b1;
                        state_reg <= S_CORD;
                    end
                end
                S_CORD:
                begin
                    if (cd_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        vibe_cnt_reg  <= vibe_next;
                        quake_reg     <= quake_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    y_reg     <= s_axis_tdata[29:15];
                    z_reg     <= s_axis_tdata[44:30];
                    sum_reg   <= '0;
                    sq_op_reg <= in_x_abs;
                    tilt_reg  <= '0;
                end
            end
            S_SQ:
            begin
                if (sq_done)
                begin
                    sum_reg   <= sum_next;
                    rt_op_reg <= sum_next;
                    sq_op_reg <= (axis_reg == 2'd0) ? y_abs : z_abs;
                end
            end
            S_ROOT1:
            begin
                if (rt_done)
                begin
                    raw_reg <= rt_root[amed_pkg::MAG_W-1:0];
                end
            end
            S_RING:
            begin
                div_q_reg   <= total_next;
                div_rem_reg <= '0;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(TOTAL_W))
                begin
                    smooth_reg <= smooth_q;
                    sq_op_reg  <= smooth_q;
                    zneg_reg   <= z_reg[amed_pkg::AXIS_W-1];
                    zmag_reg   <= (z_abs > smooth_q) ? smooth_q : z_abs;
                end
                else if (div_sh >= WIN_DIV)
                begin
                    div_rem_reg <= DREM_W'(div_sh - WIN_DIV);
                    div_q_reg   <= {div_q_reg[TOTAL_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= DREM_W'(div_sh);
                    div_q_reg   <= {div_q_reg[TOTAL_W-2:0], 1'b0};
                end
            end
            S_FF:
            begin
                if (sq_done)
                begin
                    ff_reg    <= sq_prod;
                    sq_op_reg <= zmag_reg;
                end
            end
            S_ZZ:
            begin
                if (sq_done)
                begin
                    rt_op_reg <= {{(amed_pkg::SUM_W-amed_pkg::SQ_W){1'b0}}, ff_reg - sq_prod};
                end
            end
            S_ROOT2:
            begin
                if (rt_done)
                begin
                    cd_x_reg <= zneg_reg ? rt_root[amed_pkg::MAG_W-1:0] : zmag_reg;
                    cd_y_reg <= zneg_reg ? zmag_reg : rt_root[amed_pkg::MAG_W-1:0];
                end
            end
            S_CORD:
            begin
                if (cd_done)
                begin
                    tilt_reg <= {1'b0, cd_tenths} + (zneg_reg ? {1'b0, amed_pkg::RIGHT_TENTHS}
                                                              : {amed_pkg::TILT_W{1'b0}});
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_raw_reg       <= raw_reg;
                    out_smooth_reg    <= smooth_reg;
                    out_tilt_reg      <= (tilt_reg > amed_pkg::MAX_TILT) ? amed_pkg::MAX_TILT
                                                                         : tilt_reg;
                    out_motion_reg    <= dev_s > {3'd0, motion_reg};
                    out_ff_reg        <= smooth_reg < {3'd0, free_fall_reg};
                    out_impact_reg    <= raw_reg > impact_reg;
                    out_tilt_flag_reg <= tilt_reg > tilt_lim_reg;
                    out_quake_reg     <= quake_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_quake_reg, out_tilt_flag_reg, out_impact_reg,
                            out_ff_reg, out_motion_reg, out_tilt_reg, out_smooth_reg,
                            out_raw_reg};

endmodule

### verif/tb_accel_motion_event_detector.sv
// ----------------------------------------------------------------------------
// tb_accel_motion_event_detector
// Self-checking bench for the accelerometer motion event detector. Samples are
// driven on the input stream with random gaps, results are taken with random
// stalls, and every result is compared field by field with a prediction made
// in the bench from its own copy of the window, vibration counter and
// registers. The run steps through several register settings.
// ----------------------------------------------------------------------------
module tb_accel_motion_event_detector;

    localparam int WIN = 8;

    typedef struct packed {
        logic [14:0] raw_mag;
        logic [14:0] smooth_mag;
        logic [10:0] tilt;
        logic        motion;
        logic        free_fall;
        logic        impact;
        logic        tilt_hit;
        logic        quake;
    } motion_report_t;

    class motion_scoreboard;
        logic [15:0] regs [6];
        int unsigned ring [WIN];
        int unsigned slot;
        int unsigned total;
        int unsigned vibe_cnt;
        bit          quake_on;
        motion_report_t pending [$];
        int errors;

        function void clear();
            regs[amed_pkg::CFG_FREE_FALL] = amed_pkg::RST_FREE_FALL;
            regs[amed_pkg::CFG_IMPACT]    = amed_pkg::RST_IMPACT;
            regs[amed_pkg::CFG_TILT]      = amed_pkg::RST_TILT;
            regs[amed_pkg::CFG_VIBE_DEV]  = amed_pkg::RST_VIBE_DEV;
            regs[amed_pkg::CFG_VIBE_WIN]  = amed_pkg::RST_VIBE_WIN;
            regs[amed_pkg::CFG_MOTION]    = amed_pkg::RST_MOTION;
            foreach (ring[i]) ring[i] = 1000;
            slot = 0;
            total = WIN * 1000;
            vibe_cnt = 0;
            quake_on = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            unique case (idx)
                amed_pkg::CFG_FREE_FALL: regs[idx] = val & 16'hFFF;
                amed_pkg::CFG_IMPACT:    regs[idx] = val & 16'h7FFF;
                amed_pkg::CFG_TILT:      regs[idx] = val & 16'h7FF;
                amed_pkg::CFG_VIBE_DEV:  regs[idx] = val & 16'h3FFF;
                amed_pkg::CFG_VIBE_WIN:  regs[idx] = val & 16'h3FF;
                amed_pkg::CFG_MOTION:    regs[idx] = val & 16'hFFF;
                default: ;
            endcase
        endfunction

        function int unsigned int_root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 40;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint shift_toward_zero(longint v, int s);
            if (v < 0) return -((-v) >>> s);
            return v >>> s;
        endfunction

        function int unsigned angle_tenths(longint px, longint py);
            longint acc, dx, dy;
            longint unsigned t;
            acc = 0;
            px = px * 16384;
            py = py * 16384;
            for (int i = 0; i < amed_pkg::CORDIC_STEPS; i++)
            begin
                dx = shift_toward_zero(py, i);
                dy = shift_toward_zero(px, i);
                if (py >= 0)
                begin
                    px += dx; py -= dy; acc += longint'(amed_pkg::atan_entry(4'(i)));
                end
                else
                begin
                    px -= dx; py += dy; acc -= longint'(amed_pkg::atan_entry(4'(i)));
                end
            end
            if (acc < 0) acc = 0;
            if (acc > 230400) acc = 230400;
            t = (acc + 128) >> 8;
            return (t > 900) ? 900 : t;
        endfunction

        function void note_sample(logic [47:0] d);
            int x, y, z, f, zc;
            int unsigned raw, smooth, tilt, dev_s, dev_r;
            motion_report_t r;
            x = int'($signed(d[14:0]));
            y = int'($signed(d[29:15]));
            z = int'($signed(d[44:30]));
            raw = int_root(longint'(x * x + y * y + z * z));
            total = total - ring[slot] + raw;
            ring[slot] = raw;
            slot = (slot + 1) % WIN;
            smooth = total / WIN;
            tilt = 0;
            if (smooth > 100)
            begin
                f = smooth;
                zc = z;
                if (zc > f) zc = f;
                if (zc < -f) zc = -f;
                if (zc >= 0)
                    tilt = angle_tenths(zc, int_root(f * f - zc * zc));
                else
                    tilt = 900 + angle_tenths(int_root(f * f - zc * zc), -zc);
                if (tilt > 1800) tilt = 1800;
            end
            dev_s = (smooth > 1000) ? smooth - 1000 : 1000 - smooth;
            dev_r = (raw > 1000) ? raw - 1000 : 1000 - raw;
            if (dev_r > regs[amed_pkg::CFG_VIBE_DEV])
            begin
                if (vibe_cnt < 65535) vibe_cnt++;
                if (vibe_cnt >= regs[amed_pkg::CFG_VIBE_WIN]) quake_on = 1;
            end
            else
            begin
                if (vibe_cnt > 0) vibe_cnt--;
                if (vibe_cnt < regs[amed_pkg::CFG_VIBE_WIN] / 2) quake_on = 0;
            end
            r.raw_mag    = 15'(raw);
            r.smooth_mag = 15'(smooth);
            r.tilt       = 11'(tilt);
            r.motion     = dev_s > regs[amed_pkg::CFG_MOTION];
            r.free_fall  = smooth < regs[amed_pkg::CFG_FREE_FALL];
            r.impact     = raw > regs[amed_pkg::CFG_IMPACT];
            r.tilt_hit   = tilt > regs[amed_pkg::CFG_TILT];
            r.quake      = quake_on;
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch in %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic [47:0] d);
            motion_report_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (d[14:0] !== w.raw_mag) report("raw_magnitude_mg", d[14:0], w.raw_mag);
            if (d[29:15] !== w.smooth_mag)
                report("smoothed_magnitude_mg", d[29:15], w.smooth_mag);
            if (d[40:30] !== w.tilt) report("tilt_tenths", d[40:30], w.tilt);
            if (d[41] !== w.motion) report("motion_flag", d[41], w.motion);
            if (d[42] !== w.free_fall) report("free_fall_flag", d[42], w.free_fall);
            if (d[43] !== w.impact) report("impact_flag", d[43], w.impact);
            if (d[44] !== w.tilt_hit) report("tilt_flag", d[44], w.tilt_hit);
            if (d[45] !== w.quake) report("quake_flag", d[45], w.quake);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    motion_scoreboard board = new();
    bit stream_done = 0;
    bit hold_gaps = 0;

    accel_motion_event_detector #(.AVG_WINDOW(WIN)) uut (.*);

    always #6 clk = ~clk;

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic send_sample(int x, int y, int z);
        int gap;
        gap = hold_gaps ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {3'b0, z[14:0], y[14:0], x[14:0]};
        do @(posedge clk); while (!s_axis_tready);
        board.note_sample(s_axis_tdata);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic random_samples(int count);
        int m, mode;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
            begin
                m = $urandom_range(0, 1400);
                send_sample($urandom_range(0, 2 * m) - m, $urandom_range(0, 2 * m) - m,
                            $urandom_range(0, 2 * m) - m);
            end
            else if (mode < 7)
                send_sample($urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50,
                            $urandom_range(0, 100) - 50);
            else if (mode < 9)
                send_sample($urandom_range(0, 32000) - 16000,
                            $urandom_range(0, 32000) - 16000,
                            $urandom_range(0, 32000) - 16000);
            else
                send_sample($urandom_range(0, 32767), $urandom_range(0, 32767),
                            $urandom_range(0, 32767));
        end
    endtask

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    always @(negedge clk)
        if (stream_done || $urandom_range(0, 2) == 0)
            m_axis_tready <= 1;
        else
            m_axis_tready <= ($urandom_range(0, 17) == 0);

    initial
    begin
        board.clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        send_sample(0, 0, 1000);
        send_sample(0, 0, -1000);
        send_sample(1000, 0, 0);
        send_sample(0, 0, 0);
        send_sample(16000, 16000, 16000);
        send_sample(-16000, -16000, -16000);
        send_sample(16383, -16384, 16383);
        send_sample(-16384, -16384, -16384);
        send_sample(0, 0, 0);
        send_sample(0, 0, 0);
        send_sample(40, 40, 40);
        send_sample(0, 0, 0);
        send_sample(0, 0, 0);
        send_sample(0, 0, 0);
        send_sample(0, 0, 0);
        send_sample(0, 0, 60);
        send_sample(0, 0, 0);
        send_sample(1000, 0, -5000);
        send_sample(1000, 0, 5000);
        send_sample(0, 700, 700);
        send_sample(-700, 0, -700);
        hold_gaps = 1;
        for (int i = 0; i < 6; i++) send_sample(500, 500, 500);
        hold_gaps = 0;
        drain();
        random_samples(150);
        drain();

        write_reg(amed_pkg::CFG_FREE_FALL, 16'd0);
        write_reg(amed_pkg::CFG_IMPACT, 16'd0);
        write_reg(amed_pkg::CFG_TILT, 16'd0);
        write_reg(amed_pkg::CFG_VIBE_DEV, 16'd0);
        write_reg(amed_pkg::CFG_VIBE_WIN, 16'd0);
        write_reg(amed_pkg::CFG_MOTION, 16'd0);
        random_samples(120);
        drain();

        write_reg(amed_pkg::CFG_FREE_FALL, 16'hFFFF);
        write_reg(amed_pkg::CFG_IMPACT, 16'hFFFF);
        write_reg(amed_pkg::CFG_TILT, 16'hFFFF);
        write_reg(amed_pkg::CFG_VIBE_DEV, 16'hFFFF);
        write_reg(amed_pkg::CFG_VIBE_WIN, 16'hFFFF);
        write_reg(amed_pkg::CFG_MOTION, 16'hFFFF);
        random_samples(120);
        drain();

        write_reg(amed_pkg::CFG_FREE_FALL, 16'd4000);
        write_reg(amed_pkg::CFG_IMPACT, 16'd28000);
        write_reg(amed_pkg::CFG_TILT, 16'd1800);
        write_reg(amed_pkg::CFG_VIBE_DEV, 16'd100);
        write_reg(amed_pkg::CFG_VIBE_WIN, 16'd1);
        write_reg(amed_pkg::CFG_MOTION, 16'd4000);
        random_samples(120);
        drain();

        for (int k = 0; k < 3; k++)
        begin
            write_reg(amed_pkg::CFG_FREE_FALL, 16'($urandom_range(0, 1200)));
            write_reg(amed_pkg::CFG_IMPACT, 16'($urandom_range(0, 6000)));
            write_reg(amed_pkg::CFG_TILT, 16'($urandom_range(0, 1800)));
            write_reg(amed_pkg::CFG_VIBE_DEV, 16'($urandom_range(0, 800)));
            write_reg(amed_pkg::CFG_VIBE_WIN, 16'($urandom_range(1, 12)));
            write_reg(amed_pkg::CFG_MOTION, 16'($urandom_range(0, 600)));
            random_samples(80);
            drain();
        end

        stream_done = 1;
        repeat (300) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/core/amed_pkg.sv
rtl/core/amed_square.sv
rtl/core/amed_isqrt.sv
rtl/core/amed_cordic.sv
rtl/core/accel_motion_event_detector.sv
verif/tb_accel_motion_event_detector.sv
